// ===== rtl/core/tprq_pkg.sv =====
// ----------------------------------------------------------------------------
// Task priority ready queue: shared package
// Field widths, command codes and compare modes used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tprq_pkg;

  localparam int CMD_W      = 2;
  localparam int ID_W       = 6;
  localparam int PRIO_IN_W  = 8;
  localparam int PRIO_EXT_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_RMV = 2'd2
  } cmd_t;

  typedef enum logic {
    CMP_PRIO = 1'b0,
    CMP_ID   = 1'b1
  } cmp_mode_t;

endpackage

`default_nettype wire

// ===== rtl/core/tprq_if.sv =====
// ----------------------------------------------------------------------------
// Task priority ready queue: channel interfaces
// Command channel and result channel, each a valid/ready beat with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tprq_in_if import tprq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ID_W-1:0]      task_id;
  logic [PRIO_IN_W-1:0] prio;

  modport source (output valid, output cmd, output task_id, output prio, input ready);
  modport sink   (input valid, input cmd, input task_id, input prio, output ready);
endinterface

interface tprq_out_if import tprq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] out_task;
  logic            hit;
  logic            overflow;
  logic            is_empty;

  modport source (output valid, output out_task, output hit, output overflow,
                  output is_empty, input ready);
  modport sink   (input valid, input out_task, input hit, input overflow,
                  input is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tprq_ram.sv =====
// ----------------------------------------------------------------------------
// Task priority ready queue: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tprq_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/tprq_cmp.sv =====
// ----------------------------------------------------------------------------
// Task priority ready queue: shared compare unit
// Tests a stored entry against the command key: lower priority or equal id.
// ----------------------------------------------------------------------------
`default_nettype none

module tprq_cmp import tprq_pkg::*; #(
  parameter int PRIO_BITS = 8
) (
  input  wire cmp_mode_t            mode,
  input  wire logic [ID_W-1:0]      ent_id,
  input  wire logic [PRIO_BITS-1:0] ent_prio,
  input  wire logic [ID_W-1:0]      key_id,
  input  wire logic [PRIO_BITS-1:0] key_prio,
  output logic                      flag
);

  always_comb begin
    unique case (mode)
      CMP_PRIO: flag = (ent_prio < key_prio);
      CMP_ID:   flag = (ent_id == key_id);
      default:  flag = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/task_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// Task priority ready queue
// Sorted queue of task ids, highest priority at the head, FIFO among equals.
// ----------------------------------------------------------------------------
//  channel   dir   fields                              beat taken when
//  in_bus    in    cmd, task_id, prio                  valid & ready
//  out_bus   out   out_task, hit, overflow, is_empty   valid & ready
//
//  Entries live in one RAM; a sequencer walks it with one compare unit,
//  and each entry visited is read, then compared or written.
//  Enqueue walks from the tail over the entries of lower priority.
//  Dequeue/remove visits every occupied entry, on a hit or a miss.
//  Not ready while a command is in flight; a finished result sits in the
//  output register and the next command is taken while it waits.
//  Reset clears the state, the occupancy and the output valid only; RAM contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module task_priority_ready_queue import tprq_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int PRIO_BITS = 8
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tprq_in_if.sink   in_bus,
  tprq_out_if.source out_bus
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_W + PRIO_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENQ_RD,
    ST_ENQ_CMP,
    ST_ENQ_PUT,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        occ_r, occ_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [ID_W-1:0]      key_id_r, key_id_nxt;
  logic [PRIO_BITS-1:0] key_prio_r, key_prio_nxt;
  logic [ID_W-1:0]      res_task_r, res_task_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic                 res_ovf_r, res_ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]      out_task_r, out_task_nxt;
  logic                 hit_r, hit_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 empty_r, empty_nxt;

  logic                  in_beat;
  logic [PRIO_EXT_W-1:0] in_prio_ext;
  logic [PRIO_BITS-1:0]  in_prio;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;
  logic [ID_W-1:0]       rd_id;
  logic [PRIO_BITS-1:0]  rd_prio;
  cmp_mode_t             cmp_mode;
  logic                  cmp_flag;
  logic                  idx_last;

  assign in_prio_ext = PRIO_EXT_W'(in_bus.prio);
  assign in_prio     = in_prio_ext[PRIO_BITS-1:0];
  assign in_beat     = in_bus.valid && in_bus.ready;
  assign rd_id       = ram_rdata[EW-1:PRIO_BITS];
  assign rd_prio     = ram_rdata[PRIO_BITS-1:0];
  assign idx_last    = ((CW'(idx_r) + CW'(1)) == occ_r);
  assign cmp_mode    = (state_r == ST_ENQ_CMP) ? CMP_PRIO : CMP_ID;

  tprq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  tprq_cmp #(
    .PRIO_BITS (PRIO_BITS)
  ) u_cmp (
    .mode     (cmp_mode),
    .ent_id   (rd_id),
    .ent_prio (rd_prio),
    .key_id   (key_id_r),
    .key_prio (key_prio_r),
    .flag     (cmp_flag)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    occ_nxt       = occ_r;
    cmd_nxt       = cmd_r;
    key_id_nxt    = key_id_r;
    key_prio_nxt  = key_prio_r;
    res_task_nxt  = res_task_r;
    res_hit_nxt   = res_hit_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_task_nxt  = out_task_r;
    hit_nxt       = hit_r;
    ovf_nxt       = ovf_r;
    empty_nxt     = empty_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {key_id_r, key_prio_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          cmd_nxt      = cmd_t'(in_bus.cmd);
          key_id_nxt   = in_bus.task_id;
          key_prio_nxt = in_prio;
          res_task_nxt = '0;
          res_hit_nxt  = 1'b0;
          res_ovf_nxt  = 1'b0;
          idx_nxt      = '0;
          state_nxt    = ST_DONE;
          case (in_bus.cmd) inside
            CMD_ENQ: begin
              if (occ_r == CW'(DEPTH)) begin
                res_ovf_nxt = 1'b1;
              end else if (occ_r == '0) begin
                // empty queue: drop straight into the head slot
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {in_bus.task_id, in_prio};
                occ_nxt   = occ_r + CW'(1);
              end else begin
                idx_nxt   = AW'(occ_r - CW'(1));
                state_nxt = ST_ENQ_RD;
              end
            end
            CMD_DEQ, CMD_RMV: begin
              if (occ_r != '0) begin
                state_nxt = ST_SRCH_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ENQ_RD: state_nxt = ST_ENQ_CMP;
      ST_ENQ_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + AW'(1);
        if (cmp_flag) begin
          // entry ranks below the new one: push it back one slot
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = ST_ENQ_PUT;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = ST_ENQ_RD;
          end
        end else begin
          occ_nxt   = occ_r + CW'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_ENQ_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        occ_nxt   = occ_r + CW'(1);
        state_nxt = ST_DONE;
      end
      ST_SRCH_RD: state_nxt = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if ((cmd_r == CMD_DEQ) || cmp_flag) begin
          res_hit_nxt = 1'b1;
          if (cmd_r == CMD_DEQ) begin
            res_task_nxt = rd_id;
          end
          if (idx_last) begin
            occ_nxt   = occ_r - CW'(1);
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_SH_RD;
          end
        end else if (idx_last) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_SH_RD: state_nxt = ST_SH_WR;
      ST_SH_WR: begin
        // close the gap: move the entry one slot toward the head
        ram_we    = 1'b1;
        ram_waddr = idx_r - AW'(1);
        ram_wdata = ram_rdata;
        if (idx_last) begin
          occ_nxt   = occ_r - CW'(1);
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_SH_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_task_nxt  = res_task_r;
          hit_nxt       = res_hit_r;
          ovf_nxt       = res_ovf_r;
          empty_nxt     = (occ_r == '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    cmd_r      <= cmd_nxt;
    key_id_r   <= key_id_nxt;
    key_prio_r <= key_prio_nxt;
    res_task_r <= res_task_nxt;
    res_hit_r  <= res_hit_nxt;
    res_ovf_r  <= res_ovf_nxt;
    out_task_r <= out_task_nxt;
    hit_r      <= hit_nxt;
    ovf_r      <= ovf_nxt;
    empty_r    <= empty_nxt;
  end

  assign in_bus.ready      = (state_r == ST_IDLE);
  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_task  = out_task_r;
  assign out_bus.hit       = hit_r;
  assign out_bus.overflow  = ovf_r;
  assign out_bus.is_empty  = empty_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (occ_r == $past(occ_r)) || (occ_r == $past(occ_r) + CW'(1)) ||
             (occ_r == $past(occ_r) - CW'(1)))
    else $error("occupancy moved by more than one");

  a_ovf_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ovf_r && hit_r))
    else $error("result flags both overflow and hit");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> !empty_r)
    else $error("overflow reported on an empty queue");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_task_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// Task priority ready queue: self-checking testbench
// Drives enqueue, dequeue and remove commands through the command channel,
// keeps a sorted shadow queue that predicts every reply, and compares each
// reply beat field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_task_priority_ready_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import tprq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int PRIO_BITS   = 8;
  localparam int RAND_CMDS   = 1550;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 300;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;   // unused code, must change nothing

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [ID_W-1:0]      task_id;
    logic [PRIO_IN_W-1:0] prio;
    int unsigned          gap;
  } sched_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] out_task;
    logic            hit;
    logic            overflow;
    logic            is_empty;
  } sched_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tprq_in_if  in_bus();
  tprq_out_if out_bus();

  task_priority_ready_queue #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #6 clk = ~clk;

  // Shadow of the ready queue, head at index 0
  logic [ID_W-1:0]      shadow_id   [DEPTH];
  logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
  int                   shadow_fill = 0;

  sched_cmd_t   cmd_backlog[$];
  sched_reply_t pending_replies[$];
  int           error_count = 0;

  function automatic void drop_slot(int pos);
    int i;
    for (i = pos; i + 1 < shadow_fill; i++) begin
      shadow_id[i]   = shadow_id[i + 1];
      shadow_prio[i] = shadow_prio[i + 1];
    end
    shadow_fill--;
  endfunction

  function automatic sched_reply_t apply_sched_cmd(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                                                   logic [PRIO_IN_W-1:0] p);
    sched_reply_t         r;
    logic [PRIO_BITS-1:0] pm;
    int                   pos;
    int                   i;
    r   = '0;
    pm  = p[PRIO_BITS-1:0];
    pos = 0;
    case (c)
      CMD_ENQ: begin
        if (shadow_fill >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          // land behind every entry of equal or higher priority
          while (pos < shadow_fill && pm <= shadow_prio[pos]) pos++;
          for (i = shadow_fill; i > pos; i--) begin
            shadow_id[i]   = shadow_id[i - 1];
            shadow_prio[i] = shadow_prio[i - 1];
          end
          shadow_id[pos]   = id;
          shadow_prio[pos] = pm;
          shadow_fill++;
        end
      end
      CMD_DEQ: begin
        if (shadow_fill > 0) begin
          r.out_task = shadow_id[0];
          r.hit      = 1'b1;
          drop_slot(0);
        end
      end
      CMD_RMV: begin
        while (pos < shadow_fill && shadow_id[pos] != id) pos++;
        if (pos < shadow_fill) begin
          r.hit = 1'b1;
          drop_slot(pos);
        end
      end
      default: ;
    endcase
    r.is_empty = (shadow_fill == 0);
    return r;
  endfunction

  task automatic compare_field(string name, int got, int want);
    if (got != want) begin
      error_count++;
      $display("[%0t] reply mismatch on %s: got %0d, want %0d", $realtime, name, got, want);
    end
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_cmd(logic [CMD_W-1:0] c, int id, int p, bit quiet);
    sched_cmd_t it;
    it.cmd     = c;
    it.task_id = id[ID_W-1:0];
    it.prio    = p[PRIO_IN_W-1:0];
    it.gap     = quiet ? 0 : pick_gap();
    cmd_backlog.push_back(it);
  endtask

  // Command driver
  bit          feeding = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    sched_cmd_t   it;
    sched_reply_t r;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      feeding  = 1'b0;
      gap_left = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        r = apply_sched_cmd(in_bus.cmd, in_bus.task_id, in_bus.prio);
        pending_replies.push_back(r);
        feeding = 1'b0;
      end
      if (!feeding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          it = cmd_backlog.pop_front();
          in_bus.cmd     <= it.cmd;
          in_bus.task_id <= it.task_id;
          in_bus.prio    <= it.prio;
          gap_left = it.gap;
          feeding  = 1'b1;
        end
      end
      in_bus.valid <= feeding;
    end
  end

  // Reply monitor with random backpressure
  int unsigned stall_left = 0;
  int unsigned mon_cycles = 0;

  always @(posedge clk) begin
    sched_reply_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_replies.size() == 0) begin
          error_count++;
          $display("[%0t] reply beat with nothing outstanding", $realtime);
        end else begin
          want = pending_replies.pop_front();
          compare_field("out_task", out_bus.out_task, want.out_task);
          compare_field("hit",      out_bus.hit,      want.hit);
          compare_field("overflow", out_bus.overflow, want.overflow);
          compare_field("is_empty", out_bus.is_empty, want.is_empty);
        end
      end
      mon_cycles++;
      // hold ready high through a stretch of every window
      if (mon_cycles % 5000 < 1200) begin
        stall_left = 0;
        out_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any beat
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int   phase_len;
    int   kind;
    int   id_hi;
    bit   narrow_prio;
    bit   quiet;
    int   roll;
    int   k;
    logic [CMD_W-1:0] c;

    in_bus.valid   = 1'b0;
    in_bus.cmd     = CMD_ENQ;
    in_bus.task_id = '0;
    in_bus.prio    = '0;
    out_bus.ready  = 1'b0;

    // Directed: empty queue, extremes, ties, duplicates, absent remove
    push_cmd(CMD_DEQ, 0, 0, 1'b0);
    push_cmd(CMD_RMV, 63, 0, 1'b0);
    push_cmd(CMD_NOP, 0, 0, 1'b0);
    push_cmd(CMD_ENQ, 63, 255, 1'b0);
    push_cmd(CMD_ENQ, 0, 0, 1'b0);
    push_cmd(CMD_ENQ, 5, 128, 1'b0);
    push_cmd(CMD_ENQ, 6, 128, 1'b0);
    push_cmd(CMD_ENQ, 5, 128, 1'b0);
    push_cmd(CMD_ENQ, 42, 255, 1'b0);
    push_cmd(CMD_NOP, 63, 255, 1'b0);
    push_cmd(CMD_RMV, 17, 0, 1'b0);
    push_cmd(CMD_RMV, 5, 0, 1'b0);
    push_cmd(CMD_ENQ, 21, 1, 1'b0);
    for (k = 0; k < 7; k++) push_cmd(CMD_DEQ, 0, 0, 1'b0);

    // Fill past capacity to force dropped enqueues
    for (k = 0; k < DEPTH + 4; k++)
      push_cmd(CMD_ENQ, $urandom_range(0, 63), $urandom_range(0, 255), 1'b0);

    // leave room for the final drain
    while (cmd_backlog.size() + DEPTH + 1 < RAND_CMDS) begin
      kind        = $urandom_range(0, 3);
      phase_len   = $urandom_range(40, 120);
      id_hi       = ($urandom_range(0, 1) == 0) ? 7 : 63;
      narrow_prio = $urandom_range(0, 1);
      quiet       = ($urandom_range(0, 3) == 0);
      for (k = 0; k < phase_len; k++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0: c = (roll < 85) ? CMD_ENQ : (roll < 95) ? CMD_DEQ : CMD_RMV;
          1: c = (roll < 15) ? CMD_ENQ : (roll < 75) ? CMD_DEQ : CMD_RMV;
          2: c = (roll < 40) ? CMD_ENQ : (roll < 70) ? CMD_DEQ : CMD_RMV;
          default: c = (roll < 55) ? CMD_ENQ : (roll < 75) ? CMD_DEQ : CMD_RMV;
        endcase
        if ($urandom_range(0, 99) == 0) c = CMD_NOP;
        push_cmd(c, $urandom_range(0, id_hi),
                 narrow_prio ? $urandom_range(0, 3) * 85 : $urandom_range(0, 255), quiet);
      end
    end
    // Empty the queue at the end
    for (k = 0; k < DEPTH + 1; k++) push_cmd(CMD_DEQ, 0, 0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || feeding || pending_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tprq_pkg.sv
rtl/core/tprq_if.sv
rtl/core/tprq_ram.sv
rtl/core/tprq_cmp.sv
rtl/core/task_priority_ready_queue.sv
bench/tb_task_priority_ready_queue.sv
